// ===== src/lpfe_pkg.sv =====
package lpfe_pkg;

   // Default ring length.
   localparam int PIXEL_COUNT_DEF = 12;

   // Command codes carried in the op field.
   localparam logic [1:0] OP_SWEEP_GIVEN = 2'd0;
   localparam logic [1:0] OP_SWEEP_SHOWN = 2'd1;
   localparam logic [1:0] OP_RENDER      = 2'd2;

   localparam int REQ_DATA_W = 176;
   localparam int RSP_DATA_W = 56;

   // One colour: index 0 red, 1 green, 2 blue.
   typedef logic [2:0][15:0] colour_type;

endpackage

// ===== src/led_pixel_fade_engine.sv =====
// Per-pixel linear colour fade engine for a ring of PIXEL_COUNT pixels. Every pixel holds
// a fade record (start and end colour, start and end time, and the colour last shown), all
// zero after reset. A sweep command (op 0 with the given start colour, op 1 from each
// pixel's shown colour) loads a wrapping pixel range and returns nothing. A render
// command (op 2) works out each pixel's colour at time now as start + floor((now - t0) *
// (end - start) / (t1 - t0)), clamped at both ends, and returns PIXEL_COUNT words in pixel
// order with tlast on the final one. A pixel at or before its start or at or past its end
// skips the arithmetic; one inside its fade goes through one multiply, sixteen divide
// steps and one update per channel, because the three channels share one 32 by 16
// multiplier and one radix-2 divider that settles a quotient bit per cycle. The result
// side can hold a render at each pixel word. The block takes no new word until the
// current command has finished; op 3 and sweeps that start beyond the ring are taken and
// ignored.
module led_pixel_fade_engine
   import lpfe_pkg::*;
#(
   parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // From bit 0: op[2], now[32], range_from[6], range_to[7], start_red[16],
   // start_green[16], start_blue[16], end_red[16], end_green[16], end_blue[16],
   // duration[32], one zero pad bit.
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // From bit 0: pixel_index[6], red[16], green[16], blue[16], two zero pad bits.
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int IW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam int GW = $clog2(PIXEL_COUNT + 2);
   localparam logic [IW-1:0] LAST_PIX = IW'(PIXEL_COUNT - 1);
   localparam logic [6:0]    COUNT7   = 7'(PIXEL_COUNT);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SWEEP = 3'd1;
   localparam logic [2:0] ST_PIX   = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_CHAN  = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   // Fade table.
   colour_type  start_col_ff [PIXEL_COUNT];
   colour_type  end_col_ff   [PIXEL_COUNT];
   colour_type  shown_col_ff [PIXEL_COUNT];
   logic [31:0] t0_ff        [PIXEL_COUNT];
   logic [31:0] t1_ff        [PIXEL_COUNT];

   // Sequencer.
   logic [2:0]    state_ff, state_in;
   logic [IW-1:0] pix_ff, pix_in;
   logic [GW-1:0] guard_ff, guard_in;
   logic [1:0]    ch_ff, ch_in;
   logic [3:0]    cnt_ff, cnt_in;

   // Captured command.
   logic          shown_src_ff;
   logic [31:0]   now_ff;
   logic [31:0]   tend_ff;
   logic [6:0]    to_ff;
   colour_type    given_ff;
   colour_type    target_ff;

   // Shared arithmetic.
   logic [31:0]   dt_ff, span_ff;
   logic [31:0]   rem_ff;
   logic [15:0]   qn_ff;
   logic          dir_ff;
   logic [15:0]   a_ff;
   colour_type    res_ff;

   // Result register.
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;

   logic        accept;
   logic        out_free;
   logic        sweep_done;
   logic [15:0] cur_a, cur_b, diff;
   logic        cur_dir;
   logic [47:0] prod;
   logic [48:0] num_wide;
   logic [32:0] trial;
   logic        trial_ge;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign sweep_done = (guard_ff > GW'(PIXEL_COUNT)) || ({{(7-IW){1'b0}}, pix_ff} == to_ff);

   // Operand selection for the multiply step.
   assign cur_a    = start_col_ff[pix_ff][ch_ff];
   assign cur_b    = end_col_ff[pix_ff][ch_ff];
   assign cur_dir  = (cur_b >= cur_a);
   assign diff     = cur_dir ? (cur_b - cur_a) : (cur_a - cur_b);
   assign prod     = 48'(dt_ff) * 48'(diff);
   // Falling channels round the quotient up, so the divisor less one is added first.
   assign num_wide = cur_dir ? {1'b0, prod}
                             : {1'b0, prod} + {17'd0, span_ff} - 49'd1;

   // One restoring divide step.
   assign trial    = {rem_ff, qn_ff[15]};
   assign trial_ge = (trial >= {1'b0, span_ff});

   always_comb begin
      state_in = state_ff;
      pix_in   = pix_ff;
      guard_in = guard_ff;
      ch_in    = ch_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pix_in   = IW'(req_tdata[39:34]);
               guard_in = '0;
               if (req_tdata[1:0] == OP_RENDER) begin
                  pix_in   = '0;
                  state_in = ST_PIX;
               end else if ((req_tdata[1:0] == OP_SWEEP_GIVEN ||
                             req_tdata[1:0] == OP_SWEEP_SHOWN) &&
                            ({1'b0, req_tdata[39:34]} < COUNT7)) begin
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_SWEEP: begin
            if (sweep_done) begin
               state_in = ST_IDLE;
            end else begin
               guard_in = guard_ff + GW'(1);
               if (pix_ff == LAST_PIX) begin
                  if (to_ff >= COUNT7) begin
                     state_in = ST_IDLE;
                  end
                  pix_in = '0;
               end else begin
                  pix_in = pix_ff + IW'(1);
               end
            end
         end
         ST_PIX: begin
            ch_in = '0;
            if (now_ff <= t0_ff[pix_ff] || now_ff >= t1_ff[pix_ff]) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = ST_CHAN;
            end
         end
         ST_CHAN: begin
            if (ch_ff == 2'd2) begin
               state_in = ST_EMIT;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               if (pix_ff == LAST_PIX) begin
                  state_in = ST_IDLE;
               end else begin
                  pix_in   = pix_ff + IW'(1);
                  state_in = ST_PIX;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pix_ff       <= '0;
         guard_ff     <= '0;
         ch_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PIXEL_COUNT; i++) begin
            start_col_ff[i] <= '0;
            end_col_ff[i]   <= '0;
            shown_col_ff[i] <= '0;
            t0_ff[i]        <= '0;
            t1_ff[i]        <= '0;
         end
      end else begin
         state_ff <= state_in;
         pix_ff   <= pix_in;
         guard_ff <= guard_in;
         ch_ff    <= ch_in;
         cnt_ff   <= cnt_in;

         if (state_ff == ST_SWEEP && !sweep_done) begin
            start_col_ff[pix_ff] <= shown_src_ff ? shown_col_ff[pix_ff] : given_ff;
            shown_col_ff[pix_ff] <= shown_src_ff ? shown_col_ff[pix_ff] : given_ff;
            end_col_ff[pix_ff]   <= target_ff;
            t0_ff[pix_ff]        <= now_ff;
            t1_ff[pix_ff]        <= tend_ff;
         end

         if (state_ff == ST_EMIT && out_free) begin
            shown_col_ff[pix_ff] <= res_ff;
            rsp_valid_ff         <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         shown_src_ff <= (req_tdata[1:0] == OP_SWEEP_SHOWN);
         now_ff       <= req_tdata[33:2];
         to_ff        <= req_tdata[46:40];
         given_ff     <= {req_tdata[94:79], req_tdata[78:63], req_tdata[62:47]};
         target_ff    <= {req_tdata[142:127], req_tdata[126:111], req_tdata[110:95]};
         tend_ff      <= req_tdata[33:2] + req_tdata[174:143];
      end
      if (state_ff == ST_PIX) begin
         dt_ff   <= now_ff - t0_ff[pix_ff];
         span_ff <= t1_ff[pix_ff] - t0_ff[pix_ff];
         if (now_ff <= t0_ff[pix_ff]) begin
            res_ff <= start_col_ff[pix_ff];
         end else begin
            res_ff <= end_col_ff[pix_ff];
         end
      end
      if (state_ff == ST_MUL) begin
         rem_ff <= num_wide[47:16];
         qn_ff  <= num_wide[15:0];
         dir_ff <= cur_dir;
         a_ff   <= cur_a;
      end
      if (state_ff == ST_DIV) begin
         rem_ff <= trial_ge ? 32'(trial - {1'b0, span_ff}) : trial[31:0];
         qn_ff  <= {qn_ff[14:0], trial_ge};
      end
      if (state_ff == ST_CHAN) begin
         res_ff[ch_ff] <= dir_ff ? (a_ff + qn_ff) : (a_ff - qn_ff);
      end
      if (state_ff == ST_EMIT && out_free) begin
         rsp_data_ff <= {2'b00, res_ff[2], res_ff[1], res_ff[0], 6'(pix_ff)};
         rsp_last_ff <= (pix_ff == LAST_PIX);
      end
   end

   // The partial remainder always stays below the divisor.
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < span_ff))
      else $error("divider remainder not below divisor");

   // The final word of a render always carries the last pixel index.
   a_last_pix: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[5:0] == 6'(PIXEL_COUNT - 1)))
      else $error("tlast on a word other than the final pixel");

   // A sweep never visits more pixels than the ring holds plus one.
   a_guard: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (guard_ff <= GW'(PIXEL_COUNT + 1)))
      else $error("sweep walk ran past its bound");

   // A word is only produced while a render is in progress.
   a_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == ST_EMIT))
      else $error("result word raised outside a render");

endmodule

// ===== tb/led_pixel_fade_engine_test.sv =====
module led_pixel_fade_engine_test;
   import lpfe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPIX = PIXEL_COUNT_DEF;
   localparam int TIMEOUT_CYCLES = 2000000;

   // One expected pixel report from a render command.
   typedef struct packed {
      logic [5:0]  index;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic        last;
   } pixel_report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // From bit 0: op, now, range_from, range_to, start rgb, end rgb, duration, pad.
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // From bit 0: pixel_index, red, green, blue, pad.
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // The testbench's own copy of the per-pixel fade table.
   colour_type     fade_start [NPIX];
   colour_type     fade_end   [NPIX];
   logic [31:0]    stamp_from [NPIX];
   logic [31:0]    stamp_to   [NPIX];
   colour_type     shown      [NPIX];

   pixel_report_type pending_pixels[$];
   int             mismatch_count = 0;
   int             cycle_count = 0;
   int             hold_off_cycles = 0;
   bit             sink_quiet = 1'b0;

   led_pixel_fade_engine uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // The run is bounded so that a hung handshake cannot stall it for ever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= TIMEOUT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // Exact integer fade of one channel, rounded down.
   function automatic logic [15:0] fade_channel(input logic [15:0] a, input logic [15:0] b,
                                                input logic [31:0] dt, input logic [31:0] span);
      logic [63:0] mag;
      logic [63:0] q;
      if (span == 0) return a;
      if (b >= a) begin
         mag = 64'(dt) * 64'(b - a);
         q = mag / span;
         if (q > 64'(b - a)) q = 64'(b - a);
         return a + q[15:0];
      end
      mag = 64'(dt) * 64'(a - b);
      q = (mag + 64'(span) - 1) / span;
      if (q > 64'(a - b)) q = 64'(a - b);
      return a - q[15:0];
   endfunction

   // Updates the table for one command word and queues the pixel reports it causes.
   task automatic predict_fade(input logic [REQ_DATA_W-1:0] w);
      logic [1:0]  op;
      logic [31:0] now;
      logic [31:0] dur;
      int          from;
      int          upto;
      int          pix;
      colour_type  given;
      colour_type  target;
      pixel_report_type rep;
      op = w[1:0];
      now = w[33:2];
      from = w[39:34];
      upto = w[46:40];
      given[0] = w[62:47];
      given[1] = w[78:63];
      given[2] = w[94:79];
      target[0] = w[110:95];
      target[1] = w[126:111];
      target[2] = w[142:127];
      dur = w[174:143];
      if (op == OP_SWEEP_GIVEN || op == OP_SWEEP_SHOWN) begin
         if (from >= NPIX) return;
         pix = from;
         for (int g = 0; g <= NPIX && pix != upto; g++) begin
            if (op == OP_SWEEP_GIVEN) shown[pix] = given;
            fade_start[pix] = shown[pix];
            fade_end[pix] = target;
            stamp_from[pix] = now;
            stamp_to[pix] = now + dur;
            pix++;
            if (pix == NPIX) begin
               if (upto >= NPIX) break;
               pix = 0;
            end
         end
      end else if (op == OP_RENDER) begin
         for (int p = 0; p < NPIX; p++) begin
            if (now <= stamp_from[p]) shown[p] = fade_start[p];
            else if (now >= stamp_to[p]) shown[p] = fade_end[p];
            else
               for (int k = 0; k < 3; k++)
                  shown[p][k] = fade_channel(fade_start[p][k], fade_end[p][k],
                                             now - stamp_from[p], stamp_to[p] - stamp_from[p]);
            rep.index = p[5:0];
            rep.red = shown[p][0];
            rep.green = shown[p][1];
            rep.blue = shown[p][2];
            rep.last = (p == NPIX - 1);
            pending_pixels.push_back(rep);
         end
      end
   endtask

   function automatic int short_or_long_gap();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) :
             ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
   endfunction

   // Offers one command word, waits for it to be taken and then predicts it. With no gap
   // the valid line simply stays high into the next word.
   task automatic send_word(input logic [1:0] op, input logic [31:0] now,
                            input logic [5:0] from, input logic [6:0] upto,
                            input colour_type s, input colour_type e, input logic [31:0] dur,
                            input bit gaps = 1'b1);
      logic [REQ_DATA_W-1:0] w;
      int gap;
      gap = gaps ? short_or_long_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      w = {1'b0, dur, e[2], e[1], e[0], s[2], s[1], s[0], upto, from, now, op};
      req_tvalid <= 1'b1;
      req_tdata <= w;
      do @(posedge clock); while (!req_tready);
      predict_fade(w);
   endtask

   // The result side stalls at random, and for a long stretch when asked to.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else if (sink_quiet) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 9) < 7);
      end
   end

   // Every accepted pixel word is compared with the oldest expected report.
   always @(posedge clock) begin
      pixel_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h", rsp_tdata));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_tdata[5:0] !== want.index)
               report_mismatch($sformatf("index %0d, want %0d", rsp_tdata[5:0], want.index));
            if (rsp_tdata[21:6] !== want.red)
               report_mismatch($sformatf("pixel %0d red %h, want %h", want.index,
                                         rsp_tdata[21:6], want.red));
            if (rsp_tdata[37:22] !== want.green)
               report_mismatch($sformatf("pixel %0d green %h, want %h", want.index,
                                         rsp_tdata[37:22], want.green));
            if (rsp_tdata[53:38] !== want.blue)
               report_mismatch($sformatf("pixel %0d blue %h, want %h", want.index,
                                         rsp_tdata[53:38], want.blue));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("pixel %0d last %b, want %b", want.index,
                                         rsp_tlast, want.last));
         end
      end
   end

   function automatic colour_type random_colour();
      colour_type c;
      for (int k = 0; k < 3; k++)
         case ($urandom_range(0, 5))
            0: c[k] = 16'h0000;
            1: c[k] = 16'hFFFF;
            default: c[k] = 16'($urandom);
         endcase
      return c;
   endfunction

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // Extremes of the fields, every command, wrap-around, empty and out-of-ring ranges.
   task automatic test_directed();
      colour_type black;
      colour_type white;
      black = '0;
      white = '1;
      send_word(OP_RENDER, 32'd0, 6'd0, 7'd0, black, black, 32'd0);
      send_word(OP_SWEEP_GIVEN, 32'd100, 6'd0, 7'd64, black, white, 32'd1000);
      send_word(OP_RENDER, 32'd100, 6'd0, 7'd0, black, black, 32'd0);
      send_word(OP_RENDER, 32'd333, 6'd0, 7'd0, black, black, 32'd0);
      send_word(OP_SWEEP_SHOWN, 32'd400, 6'd10, 7'd2, white, black, 32'd7);
      send_word(OP_RENDER, 32'd403, 6'd0, 7'd0, black, black, 32'd0);
      send_word(OP_RENDER, 32'd2000, 6'd0, 7'd0, black, black, 32'd0);
      // An empty range, a start beyond the ring and the unused opcode change nothing.
      send_word(OP_SWEEP_GIVEN, 32'd5, 6'd4, 7'd4, white, white, 32'd1);
      send_word(OP_SWEEP_GIVEN, 32'd5, 6'd63, 7'd127, white, white, 32'd1);
      send_word(2'd3, 32'hFFFFFFFF, 6'd63, 7'd127, white, white, 32'hFFFFFFFF);
      send_word(OP_RENDER, 32'd2001, 6'd0, 7'd0, black, black, 32'd0);
      // Zero duration, and an end time that wraps below the start time.
      send_word(OP_SWEEP_GIVEN, 32'd50, 6'd3, 7'd5, white, black, 32'd0);
      send_word(OP_SWEEP_GIVEN, 32'hFFFFFF00, 6'd6, 7'd100, black, white, 32'h00001000);
      send_word(OP_RENDER, 32'hFFFFFF00, 6'd0, 7'd0, black, black, 32'd0);
      send_word(OP_RENDER, 32'hFFFFFFFF, 6'd0, 7'd0, black, black, 32'd0);
      // A sweep starting at the last pixel wraps round almost the whole ring.
      send_word(OP_SWEEP_GIVEN, 32'd10, 6'd11, 7'd10, white, black, 32'hFFFFFFFF);
      send_word(OP_RENDER, 32'h80000000, 6'd0, 7'd0, black, black, 32'd0);
      wait_for_drain();
   endtask

   // Mostly sweeps followed by renders inside the fades, with some noise words.
   task automatic test_random(input int count);
      logic [31:0] clock_ms;
      logic [1:0]  op;
      logic [6:0]  upto;
      clock_ms = $urandom;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(0, 9) < 4) ? OP_RENDER : 2'($urandom_range(0, 1));
         if ($urandom_range(0, 29) == 0) op = 2'd3;
         upto = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(0, NPIX));
         clock_ms += $urandom_range(0, 300);
         if ($urandom_range(0, 25) == 0) clock_ms = $urandom;
         send_word(op, clock_ms,
                   ($urandom_range(0, 15) == 0) ? 6'($urandom) : 6'($urandom_range(0, NPIX - 1)),
                   upto, random_colour(), random_colour(),
                   ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 1000));
      end
      wait_for_drain();
   endtask

   // The result side holds off while renders keep coming, so the block must stall its input.
   task automatic test_backpressure();
      colour_type c;
      c = '0;
      hold_off_cycles = 3000;
      for (int i = 0; i < 4; i++)
         send_word(OP_RENDER, $urandom, 6'd0, 7'd0, c, c, 32'd0, 1'b0);
      wait_for_drain();
   endtask

   // Back-to-back words with a result side that never stalls.
   task automatic test_no_idling();
      sink_quiet = 1'b1;
      for (int i = 0; i < 30; i++)
         send_word(2'($urandom_range(0, 2)), $urandom_range(0, 2000), 6'($urandom_range(0, 11)),
                   7'($urandom_range(0, 12)), random_colour(), random_colour(),
                   $urandom_range(0, 2000), 1'b0);
      wait_for_drain();
      sink_quiet = 1'b0;
   endtask

   initial begin
      for (int p = 0; p < NPIX; p++) begin
         fade_start[p] = '0;
         fade_end[p] = '0;
         stamp_from[p] = '0;
         stamp_to[p] = '0;
         shown[p] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(420);
      test_no_idling();
      // Let any trailing sweep finish before deciding.
      repeat (100) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
